[hw/rtl/wcts_pkg.sv]
`default_nettype none

package wcts_pkg;

    // Default sizes of the view and of the reciprocal table.
    localparam int unsigned VIEW_HEIGHT_DEFAULT   = 64;
    localparam int unsigned SCALE_ENTRIES_DEFAULT = 2048;

    // Field widths of the input and result beats.
    localparam int unsigned X_W      = 10;
    localparam int unsigned SCALE_W  = 12;
    localparam int unsigned TILE_W   = 8;
    localparam int unsigned COLUMN_W = 7;
    localparam int unsigned ROW_W    = 10;
    localparam int unsigned TEXEL_W  = 7;

    // The step is an 8.24 fixed-point value: 2^30 divided by the scale.
    localparam int unsigned         STEP_W      = 32;
    localparam int unsigned         STEP_FRAC_W = 24;
    localparam logic [STEP_W-1:0]   RECIP_NUM   = 32'h4000_0000;

endpackage : wcts_pkg

`default_nettype wire

[hw/rtl/wcts_recip_rom.sv]
`default_nettype none

// Reciprocal table: entry i holds 2^30 / i, entry 0 holds 0.
// The read data is registered, so it appears in the cycle after a read with rd_en set.
module wcts_recip_rom #(
    parameter int unsigned SCALE_ENTRIES = wcts_pkg::SCALE_ENTRIES_DEFAULT
) (
    input  wire logic                              aclk,
    input  wire logic                              rd_en,
    input  wire logic [$clog2(SCALE_ENTRIES)-1:0]  rd_addr,
    output logic      [wcts_pkg::STEP_W-1:0]       rd_data
);

    logic [wcts_pkg::STEP_W-1:0] rom_values [SCALE_ENTRIES];
    logic [wcts_pkg::STEP_W-1:0] rd_data_reg;

    for (genvar g = 0; g < SCALE_ENTRIES; g++) begin : g_entry
        localparam logic [wcts_pkg::STEP_W-1:0] EntryValue =
            (g == 0) ? '0 : wcts_pkg::STEP_W'(wcts_pkg::RECIP_NUM / ((g == 0) ? 1 : g));
        assign rom_values[g] = EntryValue;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= rom_values[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : wcts_recip_rom

`default_nettype wire

[hw/rtl/wall_column_texel_scaler.sv]
`default_nettype none

// Channel   Direction  Handshake          tdata / tuser / tlast
// s_        in         s_tvalid/s_tready  screen_x, scale, tile, art_column
// m_        out        m_tvalid/m_tready  out_x, screen_row, out_tile, out_column,
//                                         texel_row; tlast = last_row
//
// A column request with a nonzero scale goes through setup (reciprocal table
// read, then the clip offset multiply) and then draws one row per cycle while
// the result side is ready. A scale of zero is accepted and gives no beats.
// The walk advances only when the result register is empty or being taken, so
// m_tready stalls it. The next request is taken as soon as the last row is
// loaded into the result register. Reset is synchronous and active low; it
// clears the control state.

module wall_column_texel_scaler #(
    parameter int unsigned VIEW_HEIGHT   = wcts_pkg::VIEW_HEIGHT_DEFAULT,
    parameter int unsigned SCALE_ENTRIES = wcts_pkg::SCALE_ENTRIES_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [9:0] screen_x, [21:10] scale, [29:22] tile, [36:30] art_column, [39:37] zero
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [9:0] out_x, [19:10] screen_row, [27:20] out_tile, [34:28] out_column,
    // [41:35] texel_row, [47:42] zero
    output logic      [47:0] m_tdata,
    // last_row: set on the final row of the column
    output logic             m_tlast
);

    localparam int unsigned SCALE_AW = $clog2(SCALE_ENTRIES);
    localparam int unsigned HEIGHT_W = wcts_pkg::SCALE_W + 1;
    localparam int unsigned OFFSET_W = HEIGHT_W - 1;
    localparam int unsigned ROWS_W   = $clog2(VIEW_HEIGHT + 1);
    localparam int unsigned CHECK_W  = wcts_pkg::ROW_W + 2;
    localparam int unsigned STEP_W   = wcts_pkg::STEP_W;
    localparam int unsigned FRAC_W   = wcts_pkg::STEP_FRAC_W;
    localparam int unsigned TEXEL_W  = wcts_pkg::TEXEL_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_WALK
    } state_t;

    // Unpacked input beat.
    logic [wcts_pkg::X_W-1:0]      in_x;
    logic [wcts_pkg::SCALE_W-1:0]  in_scale;
    logic [wcts_pkg::TILE_W-1:0]   in_tile;
    logic [wcts_pkg::COLUMN_W-1:0] in_column;

    assign in_x      = s_tdata[9:0];
    assign in_scale  = s_tdata[21:10];
    assign in_tile   = s_tdata[29:22];
    assign in_column = s_tdata[36:30];

    // Request decode: clamp the scale, then decide between a centered and a
    // clipped column. The height is twice the clamped scale.
    logic                  in_accept;
    logic                  scale_over;
    logic [SCALE_AW-1:0]   scale_clamped;
    logic [HEIGHT_W-1:0]   height;
    logic                  clipped;
    logic [OFFSET_W-1:0]   clip_offset;
    logic [wcts_pkg::ROW_W-1:0] top_row;
    logic [ROWS_W-1:0]     row_count;

    assign in_accept     = s_tvalid && s_tready;
    assign scale_over    = HEIGHT_W'(in_scale) >= HEIGHT_W'(SCALE_ENTRIES);
    assign scale_clamped = scale_over ? SCALE_AW'(SCALE_ENTRIES - 1)
                                      : in_scale[SCALE_AW-1:0];
    assign height        = HEIGHT_W'({scale_clamped, 1'b0});
    assign clipped       = height >= HEIGHT_W'(VIEW_HEIGHT);
    assign clip_offset   = OFFSET_W'((height - HEIGHT_W'(VIEW_HEIGHT)) >> 1);
    assign top_row       = wcts_pkg::ROW_W'((HEIGHT_W'(VIEW_HEIGHT) - height) >> 1);
    assign row_count     = clipped ? ROWS_W'(VIEW_HEIGHT) : ROWS_W'(height);

    // Reciprocal table, read in the accept cycle.
    logic [STEP_W-1:0] rom_data;

    wcts_recip_rom #(
        .SCALE_ENTRIES (SCALE_ENTRIES)
    ) u_recip_rom (
        .aclk    (aclk),
        .rd_en   (in_accept),
        .rd_addr (scale_clamped),
        .rd_data (rom_data)
    );

    // Walk state. The texel position is kept as one 8.24 word: the low seven bits
    // of its integer byte are the texel index and wrap; its low 24 bits are the fraction.
    state_t                         state_reg;
    logic                           clipped_reg;
    logic [OFFSET_W-1:0]            offset_reg;
    logic [STEP_W-1:0]              step_reg;
    logic [STEP_W-1:0]              pos_reg;
    logic [ROWS_W-1:0]              rows_reg;
    logic [wcts_pkg::ROW_W-1:0]     row_reg;
    logic [wcts_pkg::X_W-1:0]       x_reg;
    logic [wcts_pkg::TILE_W-1:0]    tile_reg;
    logic [wcts_pkg::COLUMN_W-1:0]  column_reg;

    // Result register.
    logic                           m_tvalid_reg;
    logic                           m_tlast_reg;
    logic [wcts_pkg::X_W-1:0]       out_x_reg;
    logic [wcts_pkg::ROW_W-1:0]     out_row_reg;
    logic [wcts_pkg::TILE_W-1:0]    out_tile_reg;
    logic [wcts_pkg::COLUMN_W-1:0]  out_column_reg;
    logic [TEXEL_W-1:0]             out_texel_reg;

    // The start position of a clipped column is the clip offset times the
    // step, kept modulo 2^32.
    logic [STEP_W+OFFSET_W-1:0]     start_product;
    logic                           out_free;
    logic                           out_load;
    logic                           last_beat;

    assign start_product = (STEP_W + OFFSET_W)'(offset_reg) * (STEP_W + OFFSET_W)'(rom_data);
    assign out_free      = !m_tvalid_reg || m_tready;
    assign out_load      = (state_reg == ST_WALK) && out_free;
    assign last_beat     = rows_reg == ROWS_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // A new row loads the result register; otherwise a taken beat
            // empties it.
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept && (in_scale != '0)) begin
                        state_reg   <= ST_LOOKUP;
                        clipped_reg <= clipped;
                        offset_reg  <= clip_offset;
                        rows_reg    <= row_count;
                        row_reg     <= clipped ? '0 : top_row;
                        x_reg       <= in_x;
                        tile_reg    <= in_tile;
                        column_reg  <= in_column;
                    end
                end
                ST_LOOKUP: begin
                    state_reg <= ST_WALK;
                    step_reg  <= rom_data;
                    pos_reg   <= clipped_reg ? start_product[STEP_W-1:0] : '0;
                end
                ST_WALK: begin
                    if (out_free) begin
                        m_tlast_reg    <= last_beat;
                        out_x_reg      <= x_reg;
                        out_row_reg    <= row_reg;
                        out_tile_reg   <= tile_reg;
                        out_column_reg <= column_reg;
                        out_texel_reg  <= pos_reg[FRAC_W +: TEXEL_W];
                        pos_reg        <= pos_reg + step_reg;
                        row_reg        <= row_reg + wcts_pkg::ROW_W'(1);
                        rows_reg       <= rows_reg - ROWS_W'(1);
                        if (last_beat) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {6'd0, out_texel_reg, out_column_reg, out_tile_reg,
                       out_row_reg, out_x_reg};

    // A walk in progress always has rows left to draw.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> rows_reg != '0)
        else $error("walk running with no rows left");

    // The rows still to draw never run past the bottom of the view.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |->
            (CHECK_W'(row_reg) + CHECK_W'(rows_reg)) <= CHECK_W'(VIEW_HEIGHT))
        else $error("walk would run past the view");

    // A request with a nonzero scale goes to the table lookup next.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (in_scale != '0)) |=> state_reg == ST_LOOKUP)
        else $error("nonzero request not looked up");

    // Loading the last row ends the walk and frees the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && out_free && last_beat) |=> (m_tlast && s_tready))
        else $error("last row did not end the walk");

endmodule : wall_column_texel_scaler

`default_nettype wire
